@@ src/mmu_page_walk_memory_access_assert.svh @@
// Assertion macros shared by the block's modules.
// Each macro expects clk_i in the scope where it is used; MPW_ASSERT also expects rst_ni.
`ifndef MMU_PAGE_WALK_MEMORY_ACCESS_ASSERT_SVH
`define MMU_PAGE_WALK_MEMORY_ACCESS_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MPW_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mpw assertion failed");

`define MPW_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("mpw assertion failed");

`else

`define MPW_ASSERT(label, prop)

`define MPW_ASSERT_ALWAYS(label, prop)

`endif

`endif

@@ src/mpw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mpw_pkg;

  localparam int VA_W       = 53;
  localparam int DATA_W     = 64;
  localparam int PG_BITS    = 13;
  localparam int IDX_W      = 10;
  localparam int ROOT_W     = 20;
  localparam int PROT_W     = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_FETCH  = 3'd2;
  localparam logic [2:0] KIND_PREAD  = 3'd3;
  localparam logic [2:0] KIND_PWRITE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROT   = 2'd2;

  localparam int PTE_P = 0;
  localparam int PTE_R = 1;
  localparam int PTE_W = 2;
  localparam int PTE_X = 3;
  localparam int PTE_U = 4;
  localparam int PTE_A = 5;
  localparam int PTE_D = 6;

  typedef enum logic [1:0] {
    FLT_NONE,
    FLT_PAGE,
    FLT_BAD,
    FLT_PROT
  } fault_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SETUP,
    OP_WALK_RD,
    OP_WALK_NEXT,
    OP_LEAF,
    OP_RD0,
    OP_RD1,
    OP_MERGE,
    OP_WR0,
    OP_WR1,
    OP_FAULT,
    OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_WALK_RD,
    S_WALK_CHK,
    S_PHYS,
    S_RD1,
    S_MERGE,
    S_WR0,
    S_WR1,
    S_PEND,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e    op;
    logic   hi;
    fault_e code;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic bad_item;
    logic direct;
    logic split;
    logic part_hi;
    logic top_over;
    logic table_bad;
    logic walk_fail;
    logic leaf;
    logic phys_bad;
    logic prot_hit;
    logic is_write;
    logic two_words;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [VA_W-1:0]   address;
    logic [3:0]        access_size;
    logic [DATA_W-1:0] write_data;
    logic              user_mode;
    logic              xlate_off;
  } item_t;

endpackage

`default_nettype wire

@@ src/mpw_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mpw_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [52:0] address;
  logic [3:0]  access_size;
  logic [63:0] write_data;
  logic        user_mode;
  logic        xlate_off;

  modport source (output valid, kind, address, access_size, write_data, user_mode,
                  xlate_off, input ready);
  modport sink (input valid, kind, address, access_size, write_data, user_mode,
                xlate_off, output ready);
endinterface

interface mpw_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic [1:0]  fault;

  modport source (output valid, read_data, fault, input ready);
  modport sink (input valid, read_data, fault, output ready);
endinterface

interface mpw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [20:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/mpw_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mpw_ram #(
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 17
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/mpw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "mmu_page_walk_memory_access_assert.svh"

module mpw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mpw_pkg::sts_t sts_i,
  output mpw_pkg::cmd_t      cmd_o
);
  import mpw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.hi   = 1'b0;
    cmd_o.code = FLT_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.bad_item) begin
          cmd_o.op   = OP_FAULT;
          cmd_o.code = FLT_BAD;
          state_d    = S_DONE;
        end else begin
          cmd_o.op = OP_SETUP;
          state_d  = sts_i.direct ? S_PHYS : S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (sts_i.table_bad) begin
          cmd_o.op   = OP_FAULT;
          cmd_o.code = FLT_PAGE;
          state_d    = S_DONE;
        end else begin
          cmd_o.op = OP_WALK_RD;
          state_d  = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        priority if (sts_i.walk_fail) begin
          cmd_o.op   = OP_FAULT;
          cmd_o.code = FLT_PAGE;
          state_d    = S_DONE;
        end else if (sts_i.leaf) begin
          cmd_o.op = OP_LEAF;
          state_d  = S_PHYS;
        end else begin
          cmd_o.op = OP_WALK_NEXT;
          state_d  = S_WALK_RD;
        end
      end
      S_PHYS: begin
        priority if (sts_i.phys_bad) begin
          cmd_o.op   = OP_FAULT;
          cmd_o.code = FLT_BAD;
          state_d    = S_DONE;
        end else if (sts_i.is_write && sts_i.prot_hit) begin
          cmd_o.op   = OP_FAULT;
          cmd_o.code = FLT_PROT;
          state_d    = S_DONE;
        end else begin
          cmd_o.op = OP_RD0;
          state_d  = S_RD1;
        end
      end
      S_RD1: begin
        cmd_o.op = OP_RD1;
        state_d  = S_MERGE;
      end
      S_MERGE: begin
        cmd_o.op = OP_MERGE;
        state_d  = sts_i.is_write ? S_WR0 : S_PEND;
      end
      S_WR0: begin
        cmd_o.op = OP_WR0;
        state_d  = sts_i.two_words ? S_WR1 : S_PEND;
      end
      S_WR1: begin
        cmd_o.op = OP_WR1;
        state_d  = S_PEND;
      end
      S_PEND: begin
        priority if (sts_i.split && !sts_i.part_hi && sts_i.top_over) begin
          cmd_o.op   = OP_FAULT;
          cmd_o.code = FLT_BAD;
          state_d    = S_DONE;
        end else if (sts_i.split && !sts_i.part_hi) begin
          cmd_o.op = OP_SETUP;
          cmd_o.hi = 1'b1;
          state_d  = S_WALK_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `MPW_ASSERT(a_no_accept_clear, state_q == S_CLEAR |-> !in_ready_o)
  `MPW_ASSERT(a_out_free, cmd_o.op == OP_OUT |-> !sts_i.out_busy)
  `MPW_ASSERT(a_walk_pair, state_q == S_WALK_RD && !sts_i.table_bad |=> state_q == S_WALK_CHK)

endmodule

`default_nettype wire

@@ src/mpw_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "mmu_page_walk_memory_access_assert.svh"

module mpw_dpath #(
  parameter int MAW = 20
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire mpw_pkg::cmd_t                      cmd_i,
  output mpw_pkg::sts_t                           sts_o,
  input  wire mpw_pkg::item_t                     item_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [mpw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [mpw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                               out_ready_i,
  output logic                                    out_valid_o,
  output logic [mpw_pkg::DATA_W-1:0]              read_data_o,
  output logic [1:0]                              fault_o
);
  import mpw_pkg::*;

  localparam int WW  = MAW - 3;
  localparam int FW  = MAW - PG_BITS;
  localparam int PGW = ((MAW > ROOT_W) ? MAW : ROOT_W) - PG_BITS;
  localparam int PW  = (MAW > PROT_W) ? MAW : PROT_W;
  localparam logic [MAW:0] MEM_END   = {1'b1, {MAW{1'b0}}};
  localparam logic [PGW:0] MEM_PAGES = (PGW + 1)'(1) << FW;

  item_t             item_q;
  logic              paging_q;
  logic [ROOT_W-1:0] root_q;
  logic [PROT_W-1:0] prot_q;
  logic [VA_W-1:0]   pva_q;
  logic [3:0]        pn_q;
  logic [2:0]        pdone_q;
  logic              part_hi_q;
  logic [MAW-1:0]    pa_q;
  logic [1:0]        level_q;
  logic [PGW-1:0]    table_q;
  logic [WW-1:0]     ea_q;
  logic [WW-1:0]     clr_q;
  logic [DATA_W-1:0] buf0_q, mrg0_q, mrg1_q, acc_q;
  fault_e            flt_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  fault_e            out_flt_q;

  logic              ram_we;
  logic [WW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic              direct, is_write, bad_item, split, leaf, perm_ok;
  logic [13:0]       lo14;
  logic [IDX_W-1:0]  idx;
  logic [WW-1:0]     ea, w0;
  logic [2:0]        off;
  logic [7:0]        bmask;
  logic [15:0]       be16;
  logic [127:0]      old128, shifted, wr128, new128;
  logic [DATA_W-1:0] rd_val, pdata, pte_wb;

  mpw_ram #(.WIDTH(DATA_W), .ADDR_W(WW)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign direct   = (item_q.kind >= KIND_PREAD) || !paging_q || item_q.xlate_off;
  assign is_write = (item_q.kind == KIND_WRITE) || (item_q.kind == KIND_PWRITE);
  assign bad_item = (item_q.kind > KIND_PWRITE) ||
                    !((item_q.access_size == 4'd1) || (item_q.access_size == 4'd2) ||
                      (item_q.access_size == 4'd4) || (item_q.access_size == 4'd8));
  assign lo14     = 14'h2000 - {1'b0, item_q.address[PG_BITS-1:0]};
  assign split    = !direct && (lo14 < {10'd0, item_q.access_size});
  assign leaf     = (level_q == 2'd3);
  assign ea       = {table_q[FW-1:0], idx};
  assign w0       = pa_q[MAW-1:3];
  assign off      = pa_q[2:0];

  always_comb begin
    unique case (level_q)
      2'd0: idx = pva_q[52:43];
      2'd1: idx = pva_q[42:33];
      2'd2: idx = pva_q[32:23];
      2'd3: idx = pva_q[22:13];
      default: idx = pva_q[22:13];
    endcase
  end

  always_comb begin
    unique case (item_q.kind)
      KIND_WRITE: perm_ok = ram_rdata[PTE_W];
      KIND_FETCH: perm_ok = ram_rdata[PTE_X];
      default:    perm_ok = ram_rdata[PTE_R];
    endcase
    if (item_q.user_mode && !ram_rdata[PTE_U]) perm_ok = 1'b0;
  end

  always_comb begin
    pte_wb        = ram_rdata;
    pte_wb[PTE_A] = 1'b1;
    if (is_write) pte_wb[PTE_D] = 1'b1;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bmask[i] = (4'(i) < pn_q);
    end
    be16    = {8'd0, bmask} << off;
    old128  = {ram_rdata, buf0_q};
    shifted = old128 >> {off, 3'b000};
    for (int i = 0; i < 8; i++) begin
      rd_val[i*8 +: 8] = bmask[i] ? shifted[i*8 +: 8] : 8'd0;
    end
    pdata = item_q.write_data >> {pdone_q, 3'b000};
    wr128 = {64'd0, pdata} << {off, 3'b000};
    for (int b = 0; b < 16; b++) begin
      new128[b*8 +: 8] = be16[b] ? wr128[b*8 +: 8] : old128[b*8 +: 8];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = ea_q;
    ram_wdata = '0;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      OP_WALK_RD: ram_addr = ea;
      OP_LEAF: begin
        ram_we    = 1'b1;
        ram_wdata = pte_wb;
      end
      OP_RD0: ram_addr = w0;
      OP_RD1: ram_addr = w0 + WW'(1);
      OP_WR0: begin
        ram_we    = 1'b1;
        ram_addr  = w0;
        ram_wdata = mrg0_q;
      end
      OP_WR1: begin
        ram_we    = 1'b1;
        ram_addr  = w0 + WW'(1);
        ram_wdata = mrg1_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign sts_o.clear_last = &clr_q;
  assign sts_o.bad_item   = bad_item;
  assign sts_o.direct     = direct;
  assign sts_o.split      = split;
  assign sts_o.part_hi    = part_hi_q;
  assign sts_o.top_over   = &item_q.address[VA_W-1:PG_BITS];
  assign sts_o.table_bad  = ({1'b0, table_q} >= MEM_PAGES);
  assign sts_o.walk_fail  = !ram_rdata[PTE_P] || (|ram_rdata[DATA_W-1:MAW-5]) ||
                            (leaf && !perm_ok);
  assign sts_o.leaf       = leaf;
  assign sts_o.phys_bad   = (direct && (|item_q.address[VA_W-1:MAW])) ||
                            (({1'b0, pa_q} + (MAW + 1)'(pn_q)) > MEM_END);
  assign sts_o.prot_hit   = (PW'(pa_q) < PW'(prot_q));
  assign sts_o.is_write   = is_write;
  assign sts_o.two_words  = (({1'b0, off} + pn_q) > 4'd8);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paging_q    <= 1'b0;
      root_q      <= '0;
      prot_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PAGING: paging_q <= cfg_data_i[0];
          CFG_ROOT:   root_q   <= cfg_data_i[ROOT_W-1:0];
          CFG_PROT:   prot_q   <= cfg_data_i;
          default:    paging_q <= paging_q;
        endcase
      end
      if (cmd_i.op == OP_CLEAR) clr_q <= clr_q + WW'(1);
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        item_q <= item_i;
        acc_q  <= '0;
        flt_q  <= FLT_NONE;
      end
      OP_SETUP: begin
        level_q   <= 2'd0;
        table_q   <= PGW'(root_q[ROOT_W-1:PG_BITS]);
        part_hi_q <= cmd_i.hi;
        if (!cmd_i.hi) begin
          pva_q   <= item_q.address;
          pn_q    <= split ? lo14[3:0] : item_q.access_size;
          pdone_q <= 3'd0;
          pa_q    <= item_q.address[MAW-1:0];
        end else begin
          pva_q   <= {item_q.address[VA_W-1:PG_BITS] + (VA_W - PG_BITS)'(1),
                      {PG_BITS{1'b0}}};
          pn_q    <= item_q.access_size - lo14[3:0];
          pdone_q <= lo14[2:0];
        end
      end
      OP_WALK_RD: ea_q <= ea;
      OP_WALK_NEXT: begin
        table_q <= PGW'(ram_rdata[MAW-6:8]);
        level_q <= level_q + 2'd1;
      end
      OP_LEAF: pa_q <= {ram_rdata[MAW-6:8], pva_q[PG_BITS-1:0]};
      OP_RD1: buf0_q <= ram_rdata;
      OP_MERGE: begin
        mrg0_q <= new128[63:0];
        mrg1_q <= new128[127:64];
        if (!is_write) acc_q <= acc_q | (rd_val << {pdone_q, 3'b000});
      end
      OP_FAULT: flt_q <= cmd_i.code;
      OP_OUT: begin
        out_data_q <= ((flt_q == FLT_NONE) && !is_write) ? acc_q : '0;
        out_flt_q  <= flt_q;
      end
      default: begin
        flt_q <= flt_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign fault_o     = out_flt_q;

  `MPW_ASSERT(a_out_set, cmd_i.op == OP_OUT |=> out_valid_q)
  `MPW_ASSERT(a_out_hold, out_valid_q && !out_ready_i |=> out_valid_q)

endmodule

`default_nettype wire

@@ src/mmu_page_walk_memory_access.sv @@
// Memory access unit with a four-level page table walker over one 64-bit single-port
// memory of 2**MAW bytes. Each item is a read, write or fetch of 1, 2, 4 or 8 bytes and
// returns one result (zero-extended read data and a fault code). After reset the block
// zeroes the whole memory, one word a cycle, and takes no item until
// that pass ends; configuration writes are always taken. Items run one at a time and
// every memory access goes through the single port: each access reads two adjacent
// words and merges them, a translated access first makes four table reads, a write
// then writes one or two words back, and a translated access split across a page runs twice.
// A finished result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module mmu_page_walk_memory_access #(
  parameter int MAW = 20
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mpw_req_if.sink    req_i,
  mpw_rsp_if.source  rsp_o,
  mpw_cfg_if.sink    cfg_i
);
  import mpw_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  item_t item;
  logic  in_ready;

  assign item = '{kind:        req_i.kind,
                  address:     req_i.address,
                  access_size: req_i.access_size,
                  write_data:  req_i.write_data,
                  user_mode:   req_i.user_mode,
                  xlate_off:   req_i.xlate_off};

  assign req_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;

  mpw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_i.valid),
    .in_ready_o(in_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mpw_dpath #(.MAW(MAW)) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .item_i     (item),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .out_ready_i(rsp_o.ready),
    .out_valid_o(rsp_o.valid),
    .read_data_o(rsp_o.read_data),
    .fault_o    (rsp_o.fault)
  );

endmodule

`default_nettype wire

@@ tb/tb_mmu_page_walk_memory_access.sv @@
`timescale 1ns / 1ps

module tb_mmu_page_walk_memory_access;
  import mpw_pkg::*;

  localparam longint unsigned MEM_BYTES = 64'h100000;
  localparam int MEM_WORDS = 131072;
  localparam longint unsigned PAGE = 64'h2000;
  localparam int IDLE_LIMIT = 400000;
  localparam int RAND_ITEMS = 1700;

  typedef struct {
    logic [63:0] data;
    fault_e      fault;
  } result_t;

  typedef struct {
    item_t       it;
    bit          typed;
    logic [63:0] data;
    fault_e      fault;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mpw_req_if req();
  mpw_rsp_if rsp();
  mpw_cfg_if cfg();

  mmu_page_walk_memory_access dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  always #6 clk = ~clk;

  logic [63:0] phys_words [0:MEM_WORDS-1];
  bit          paging_q;
  logic [19:0] root_q;
  logic [20:0] prot_q;

  result_t  pending_results[$];
  dir_row_t dir_rows[$];
  int       errors = 0;
  int       results_seen = 0;
  int       idle_cycles = 0;
  bit       calm = 1'b0;
  bit       held = 1'b0;
  int       hold_left = 0;
  int       stall_left = 0;

  function automatic logic [7:0] get_byte(logic [63:0] a);
    return phys_words[a[19:3]][a[2:0]*8 +: 8];
  endfunction

  function automatic void put_byte(logic [63:0] a, logic [7:0] v);
    phys_words[a[19:3]][a[2:0]*8 +: 8] = v;
  endfunction

  function automatic bit walk_table(logic [63:0] va, int need_bit, bit user, bit wr,
                                    output logic [63:0] pa);
    logic [63:0] tbl;
    logic [63:0] ea;
    logic [63:0] pte;
    logic [63:0] frame;
    tbl = {44'd0, root_q} & ~64'h1FFF;
    pa = '0;
    for (int lvl = 0; lvl < 4; lvl++) begin
      if (tbl > MEM_BYTES - PAGE) return 1'b0;
      ea = tbl + ((va >> (43 - 10 * lvl)) & 64'h3FF) * 8;
      pte = phys_words[ea[19:3]];
      if (!pte[PTE_P]) return 1'b0;
      if (lvl == 3) begin
        if (!pte[need_bit] || (user && !pte[PTE_U])) return 1'b0;
      end
      frame = pte >> 8;
      if (frame >= (MEM_BYTES >> 13)) return 1'b0;
      if (lvl == 3) begin
        pte[PTE_A] = 1'b1;
        if (wr) pte[PTE_D] = 1'b1;
        phys_words[ea[19:3]] = pte;
      end
      tbl = frame << 13;
    end
    pa = tbl + (va & 64'h1FFF);
    return 1'b1;
  endfunction

  function automatic fault_e phys_part(logic [63:0] pa, int n, bit wr, logic [63:0] wd,
                                       output logic [63:0] v);
    v = '0;
    if (pa > MEM_BYTES || 64'(n) > MEM_BYTES - pa) return FLT_BAD;
    if (wr) begin
      if (pa < 64'(prot_q)) return FLT_PROT;
      for (int i = 0; i < n; i++) put_byte(pa + i, wd[i*8 +: 8]);
    end else begin
      for (int i = 0; i < n; i++) v[i*8 +: 8] = get_byte(pa + i);
    end
    return FLT_NONE;
  endfunction

  function automatic fault_e virt_part(logic [63:0] va, int n, logic [2:0] kind, bit user,
                                       logic [63:0] wd, output logic [63:0] v);
    logic [63:0] pa;
    int need;
    v = '0;
    need = (kind == KIND_WRITE) ? PTE_W : (kind == KIND_FETCH) ? PTE_X : PTE_R;
    if (!walk_table(va, need, user, kind == KIND_WRITE, pa)) return FLT_PAGE;
    return phys_part(pa, n, kind == KIND_WRITE, wd, v);
  endfunction

  function automatic void predict_access(item_t it, output logic [63:0] rd, output fault_e f);
    bit wr;
    int sz;
    int lo;
    logic [63:0] val;
    logic [63:0] lv;
    logic [63:0] hv;
    logic [63:0] hi_va;
    sz = int'(it.access_size);
    wr = (it.kind == KIND_WRITE || it.kind == KIND_PWRITE);
    val = '0;
    if (it.kind > KIND_PWRITE || !(sz == 1 || sz == 2 || sz == 4 || sz == 8)) begin
      f = FLT_BAD;
    end else if (it.kind >= KIND_PREAD || !paging_q || it.xlate_off) begin
      f = phys_part(64'(it.address), sz, wr, it.write_data, val);
    end else begin
      lo = 8192 - int'(it.address[12:0]);
      if (lo >= sz) begin
        f = virt_part(64'(it.address), sz, it.kind, it.user_mode, it.write_data, val);
      end else begin
        hi_va = 64'(it.address) + lo;
        f = virt_part(64'(it.address), lo, it.kind, it.user_mode, it.write_data, lv);
        if (f == FLT_NONE) begin
          if ((hi_va >> 53) != 0) f = FLT_BAD;
          else f = virt_part(hi_va, sz - lo, it.kind, it.user_mode,
                             it.write_data >> (lo * 8), hv);
        end
        if (f == FLT_NONE) val = lv | (hv << (lo * 8));
      end
    end
    rd = (f == FLT_NONE && !wr) ? val : 64'd0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic item_t mk_item(logic [2:0] kind, logic [52:0] addr, logic [3:0] sz,
                                    logic [63:0] wd, bit user, bit noxl);
    item_t it;
    it.kind = kind;
    it.address = addr;
    it.access_size = sz;
    it.write_data = wd;
    it.user_mode = user;
    it.xlate_off = noxl;
    return it;
  endfunction

  function automatic void add_row(item_t it, bit typed, logic [63:0] data, fault_e fault);
    dir_row_t r;
    r.it = it;
    r.typed = typed;
    r.data = data;
    r.fault = fault;
    dir_rows.push_back(r);
  endfunction

  task automatic send_item(item_t it, bit typed, logic [63:0] ed, fault_e ef);
    int gap;
    logic [63:0] pd;
    fault_e pf;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.kind <= it.kind;
    req.address <= it.address;
    req.access_size <= it.access_size;
    req.write_data <= it.write_data;
    req.user_mode <= it.user_mode;
    req.xlate_off <= it.xlate_off;
    req.valid <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_access(it, pd, pf);
    r.data = typed ? ed : pd;
    r.fault = typed ? ef : pf;
    pending_results.push_back(r);
  endtask

  task automatic run_rows();
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].data,
                                    dir_rows[i].fault);
    dir_rows.delete();
    req.valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [20:0] d);
    @(posedge clk);
    cfg.index <= idx;
    cfg.data <= d;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_PAGING: paging_q = d[0];
      CFG_ROOT: root_q = d[19:0];
      CFG_PROT: prot_q = d;
      default: ;
    endcase
  endtask

  task automatic set_cfg(bit pg, logic [19:0] root, logic [20:0] prot);
    settle();
    cfg_write(CFG_PAGING, 21'(pg));
    cfg_write(CFG_ROOT, 21'(root));
    cfg_write(CFG_PROT, prot);
  endtask

  task automatic build_tables();
    int fr;
    logic [63:0] pte;
    logic [7:0] flags;
    for (int l = 0; l < 4; l++) begin
      for (int n = 0; n < (1 << l); n++) begin
        for (int j = 0; j < 2; j++) begin
          fr = (1 << l) + n;
          if (l < 3) begin
            pte = {56'((2 << l) + 2 * n + j), 8'h1F};
          end else begin
            flags = '0;
            flags[PTE_P] = ($urandom_range(0, 9) != 0);
            flags[PTE_R] = ($urandom_range(0, 4) != 0);
            flags[PTE_W] = ($urandom_range(0, 4) != 0);
            flags[PTE_X] = ($urandom_range(0, 4) != 0);
            flags[PTE_U] = ($urandom_range(0, 4) != 0);
            pte = {56'(($urandom_range(0, 19) == 0) ? 200 : 32 + $urandom_range(0, 95)),
                   flags};
          end
          send_item(mk_item(KIND_PWRITE, 53'(fr * 8192 + (j ? 1023 : 0) * 8), 4'd8, pte,
                            1'b0, 1'b0), 1'b0, '0, FLT_NONE);
        end
      end
    end
    req.valid <= 1'b0;
  endtask

  function automatic logic [52:0] rand_va();
    logic [52:0] va;
    for (int l = 0; l < 4; l++) begin
      va[43 - 10 * l +: 10] = ($urandom_range(0, 99) < 85) ?
                              ($urandom_range(0, 1) ? 10'h3FF : 10'h0) :
                              10'($urandom_range(0, 1023));
    end
    va[12:0] = ($urandom_range(0, 99) < 30) ? 13'h1FF8 + 13'($urandom_range(0, 7)) :
               13'($urandom_range(0, 8191));
    return va;
  endfunction

  function automatic logic [52:0] rand_pa();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 53'($urandom_range(32'h40000, 32'hFFFFF));
    if (r < 92) return 53'(32'hFFFF0 + $urandom_range(0, 31));
    return 53'({$urandom, $urandom});
  endfunction

  function automatic item_t rand_item();
    int r;
    logic [3:0] sz;
    logic [2:0] kind;
    logic [52:0] addr;
    r = $urandom_range(0, 99);
    sz = ($urandom_range(0, 9) != 0) ? 4'(1 << $urandom_range(0, 3)) :
         4'($urandom_range(0, 15));
    if (r < 72) begin
      kind = 3'($urandom_range(0, 2));
      addr = rand_va();
    end else if (r < 95) begin
      kind = $urandom_range(0, 1) ? KIND_PREAD : KIND_PWRITE;
      addr = rand_pa();
    end else begin
      kind = 3'($urandom_range(5, 7));
      addr = 53'({$urandom, $urandom});
    end
    return mk_item(kind, addr, sz, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                   $urandom_range(0, 9) == 0);
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && results_seen >= 300) begin
      rsp.ready <= 1'b0;
      held <= 1'b1;
      hold_left <= 500;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp.ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && rsp.valid && rsp.ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item data=%h fault=%0d", $time, rsp.read_data, rsp.fault);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (rsp.read_data !== e.data) begin
          $display("%0t: read_data expected %h actual %h", $time, e.data, rsp.read_data);
          errors++;
        end
        if (rsp.fault !== e.fault) begin
          $display("%0t: fault expected %0d actual %0d", $time, e.fault, rsp.fault);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_mmu_page_walk_memory_access failed");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.kind = KIND_READ;
    req.address = '0;
    req.access_size = 4'd1;
    req.write_data = '0;
    req.user_mode = 1'b0;
    req.xlate_off = 1'b0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_PAGING;
    cfg.data = '0;
    paging_q = 1'b0;
    root_q = '0;
    prot_q = '0;
    for (int i = 0; i < MEM_WORDS; i++) phys_words[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    add_row(mk_item(KIND_PREAD, 53'h0, 4'd8, '0, 0, 0), 1, 64'd0, FLT_NONE);
    add_row(mk_item(3'd5, 53'h0, 4'd8, '1, 0, 0), 1, 64'd0, FLT_BAD);
    add_row(mk_item(3'd7, 53'h100, 4'd4, '1, 1, 1), 1, 64'd0, FLT_BAD);
    add_row(mk_item(KIND_READ, 53'h0, 4'd0, '0, 0, 0), 1, 64'd0, FLT_BAD);
    add_row(mk_item(KIND_PREAD, 53'h8, 4'd3, '0, 0, 0), 1, 64'd0, FLT_BAD);
    add_row(mk_item(KIND_PWRITE, 53'h8, 4'd15, '1, 0, 0), 1, 64'd0, FLT_BAD);
    add_row(mk_item(KIND_PREAD, 53'hFFFFC, 4'd8, '0, 0, 0), 1, 64'd0, FLT_BAD);
    add_row(mk_item(KIND_PREAD, '1, 4'd1, '0, 0, 0), 1, 64'd0, FLT_BAD);
    add_row(mk_item(KIND_PWRITE, 53'hFFFF8, 4'd8, '1, 0, 0), 1, 64'd0, FLT_NONE);
    add_row(mk_item(KIND_READ, 53'hFFFF8, 4'd8, '0, 0, 0), 1, '1, FLT_NONE);
    add_row(mk_item(KIND_FETCH, 53'hFFFFB, 4'd4, '0, 1, 0), 0, '0, FLT_NONE);
    add_row(mk_item(KIND_WRITE, 53'h100, 4'd2, 64'h0123456789ABCDEF, 0, 1), 0, '0, FLT_NONE);
    add_row(mk_item(KIND_PREAD, 53'h100, 4'd2, '0, 0, 0), 0, '0, FLT_NONE);
    run_rows();

    set_cfg(0, 20'h0, 21'h100000);
    add_row(mk_item(KIND_PWRITE, 53'hFFFF8, 4'd8, '0, 0, 0), 1, 64'd0, FLT_PROT);
    add_row(mk_item(KIND_WRITE, 53'h0, 4'd1, '1, 0, 0), 1, 64'd0, FLT_PROT);
    run_rows();

    set_cfg(0, 20'h0, 21'h0);
    build_tables();
    set_cfg(1, 20'h0, 21'h0);
    add_row(mk_item(KIND_READ, 53'h0, 4'd8, '0, 0, 0), 1, 64'd0, FLT_PAGE);
    run_rows();

    set_cfg(1, 20'h02ABC, 21'h40000);
    add_row(mk_item(KIND_READ, 53'h0, 4'd8, '0, 0, 0), 0, '0, FLT_NONE);
    add_row(mk_item(KIND_WRITE, 53'h10, 4'd4, {$urandom, $urandom}, 0, 0), 0, '0, FLT_NONE);
    add_row(mk_item(KIND_FETCH, 53'h10, 4'd8, '0, 0, 0), 0, '0, FLT_NONE);
    add_row(mk_item(KIND_READ, 53'h20, 4'd2, '0, 1, 0), 0, '0, FLT_NONE);
    add_row(mk_item(KIND_WRITE, 53'h1FFC, 4'd8, '1, 0, 0), 0, '0, FLT_NONE);
    add_row(mk_item(KIND_READ, 53'h1FFC, 4'd8, '0, 0, 0), 0, '0, FLT_NONE);
    add_row(mk_item(KIND_READ, 53'h1FFFFFFFFFFFFC, 4'd8, '0, 0, 0), 0, '0, FLT_NONE);
    add_row(mk_item(KIND_READ, 53'h0000C000000004, 4'd4, '0, 0, 0), 0, '0, FLT_NONE);
    add_row(mk_item(KIND_READ, 53'h40000, 4'd8, '0, 0, 1), 0, '0, FLT_NONE);
    run_rows();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_cfg(1, 20'h02000, 21'h0);
        1: set_cfg(1, 20'h03FFF, 21'h40000);
        2: set_cfg(0, 20'h02000, 21'($urandom_range(0, 32'h100000)));
        3: set_cfg(1, 20'hFFFFF, 21'h0);
        4: set_cfg(1, 20'h02000, 21'h100000);
        default: set_cfg(1, 20'h02000 | 20'($urandom_range(0, 8191)), 21'h40000);
      endcase
      calm = (ph == 5);
      repeat (RAND_ITEMS / 6) send_item(rand_item(), 1'b0, '0, FLT_NONE);
      req.valid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("tb_mmu_page_walk_memory_access passed");
    else
      $display("tb_mmu_page_walk_memory_access failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/mpw_pkg.sv
src/mpw_if.sv
src/mpw_ram.sv
src/mpw_ctrl.sv
src/mpw_dpath.sv
src/mmu_page_walk_memory_access.sv
tb/tb_mmu_page_walk_memory_access.sv
